>>> rtl/vn_pkg.sv
// shared constants for the vector norm block
`default_nettype none

package vn_pkg;

  localparam int unsigned FIELD_W = 32;
  localparam int unsigned LENGTH_W = 32;
  localparam int unsigned COMPONENT_BITS_DEF = 32;
  localparam int unsigned NUM_LANES = 3;

endpackage

`default_nettype wire

>>> rtl/vn_vec_if.sv
// input channel carrying one vector per beat
`default_nettype none

interface vn_vec_if;
  import vn_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [FIELD_W-1:0]  x_component;
  logic signed [FIELD_W-1:0]  y_component;
  logic signed [FIELD_W-1:0]  z_component;

  modport source (output valid, output x_component, output y_component,
                  output z_component, input ready);
  modport sink (input valid, input x_component, input y_component,
                input z_component, output ready);
endinterface

`default_nettype wire

>>> rtl/vn_len_if.sv
// output channel carrying one length per beat
`default_nettype none

interface vn_len_if;
  import vn_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [LENGTH_W-1:0]  length;

  modport source (output valid, output length, input ready);
  modport sink (input valid, input length, output ready);
endinterface

`default_nettype wire

>>> rtl/vector_norm_q16.sv
// top level: euclidean length of a q16.16 3d vector
`default_nettype none

// Takes one vector of three signed Q16.16 components per beat and returns
// floor(sqrt(x^2 + y^2 + z^2)) as an unsigned Q16.16 length, one result per
// vector, in order. Only the low COMPONENT_BITS bits of each component are
// used, sign-extended. Three lanes square the components (magnitude stage,
// multiply stage), one stage adds the squares, and the root pipeline resolves
// one result bit per stage. A new vector is accepted every cycle while the
// output is not stalled: the whole pipeline holds while a finished length is
// waiting and the output is not ready.
module vector_norm_q16 #(
  parameter int unsigned COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  vn_vec_if.sink     vec,
  vn_len_if.source   res
);
  import vn_pkg::*;

  localparam int unsigned SUM_W = 2 * COMPONENT_BITS;

  logic                    adv;
  logic [1:0]              lane_valid;
  logic [SUM_W-1:0]        sq [0:NUM_LANES-1];
  logic [FIELD_W-1:0]      comp [0:NUM_LANES-1];
  logic                    sum_valid;
  logic [SUM_W-1:0]        sum;
  logic                    root_valid;
  logic [COMPONENT_BITS-1:0] root;

  assign adv       = !root_valid || res.ready;
  assign vec.ready = adv;

  assign comp[0] = vec.x_component;
  assign comp[1] = vec.y_component;
  assign comp[2] = vec.z_component;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= '0;
    end else if (adv) begin
      lane_valid <= {lane_valid[0], vec.valid};
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    vn_lane #(.COMPONENT_BITS(COMPONENT_BITS)) u_lane (
      .clk  (clk),
      .adv  (adv),
      .comp (comp[i]),
      .sq   (sq[i])
    );
  end

  vn_merge #(.COMPONENT_BITS(COMPONENT_BITS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (lane_valid[1]),
    .sq_x      (sq[0]),
    .sq_y      (sq[1]),
    .sq_z      (sq[2]),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  vn_root #(.COMPONENT_BITS(COMPONENT_BITS)) u_root (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sum_valid),
    .value     (sum),
    .out_valid (root_valid),
    .root      (root)
  );

  assign res.valid  = root_valid;
  assign res.length = LENGTH_W'(root);

  a_lane_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(lane_valid))
    else $error("lane valid moved during a stall");

  a_ready_tracks_output: assert property (@(posedge clk) disable iff (rst)
    (root_valid && !res.ready) |=> root_valid)
    else $error("waiting length dropped");

endmodule

`default_nettype wire

>>> rtl/vn_lane.sv
// one squaring lane: magnitude stage then exact square stage
`default_nettype none

module vn_lane #(
  parameter int unsigned COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            adv,
  input  wire logic [vn_pkg::FIELD_W-1:0]      comp,
  output logic      [2*COMPONENT_BITS-1:0]     sq
);
  import vn_pkg::*;

  localparam int unsigned N = COMPONENT_BITS;

  logic [N-1:0] raw;
  logic [N-1:0] mag_next;
  logic [N-1:0] mag;

  assign raw = comp[N-1:0];
  // most negative value wraps to 2^(N-1), which is its true magnitude
  assign mag_next = raw[N-1] ? (~raw + N'(1)) : raw;

  always_ff @(posedge clk) begin
    if (adv) begin
      mag <= mag_next;
      sq  <= {{N{1'b0}}, mag} * {{N{1'b0}}, mag};
    end
  end

endmodule

`default_nettype wire

>>> rtl/vn_merge.sv
// merging stage: sum of the three lane squares
`default_nettype none

module vn_merge #(
  parameter int unsigned COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire logic [2*COMPONENT_BITS-1:0]   sq_x,
  input  wire logic [2*COMPONENT_BITS-1:0]   sq_y,
  input  wire logic [2*COMPONENT_BITS-1:0]   sq_z,
  output logic                               sum_valid,
  output logic      [2*COMPONENT_BITS-1:0]   sum
);
  import vn_pkg::*;

  localparam int unsigned SUM_W = 2 * COMPONENT_BITS;
  localparam logic [SUM_W-1:0] SUM_LIMIT = {2'b11, {(SUM_W-2){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (adv) begin
      sum_valid <= in_valid;
    end
  end

  // three squares of at most 2^(2N-2) never carry out of 2N bits
  always_ff @(posedge clk) begin
    if (adv) begin
      sum <= sq_x + sq_y + sq_z;
    end
  end

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> (sum <= SUM_LIMIT))
    else $error("summed squares exceed three times the largest square");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(sum_valid))
    else $error("merge valid moved during a stall");

endmodule

`default_nettype wire

>>> rtl/vn_root.sv
// pipelined digit-by-digit square root, one bit pair per stage
`default_nettype none

module vn_root #(
  parameter int unsigned COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire logic [2*COMPONENT_BITS-1:0]   value,
  output logic                               out_valid,
  output logic      [COMPONENT_BITS-1:0]     root
);
  import vn_pkg::*;

  localparam int unsigned N = COMPONENT_BITS;
  localparam int unsigned W = 2 * COMPONENT_BITS;

  logic [W-1:0] rem [0:N-1];
  logic [W-1:0] rt  [0:N];
  logic         vld [0:N];

  assign rem[0] = value;
  assign rt[0]  = '0;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);

    logic [W-1:0] trial;
    logic         take;

    assign trial = rt[k] + BIT;
    assign take  = (rem[k] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt[k+1] <= take ? ((rt[k] >> 1) + BIT) : (rt[k] >> 1);
      end
    end

    if (k < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[k+1] <= take ? (rem[k] - trial) : rem[k];
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = rt[N][N-1:0];

  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rt[N][W-1:N] == '0))
    else $error("root wider than a component");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(out_valid))
    else $error("root pipeline moved during a stall");

endmodule

`default_nettype wire

>>> tb/vn_norm_checker.sv
// checker: predicts each vector length and compares it with the output beats
module vn_norm_checker (
  input  logic clk,
  input  logic rst,
  vn_vec_if    vec,
  vn_len_if    res,
  output int   mismatches,
  output int   in_flight
);
  timeunit 1ns;
  timeprecision 1ps;
  import vn_pkg::*;

  localparam int unsigned TOP_PAIR   = 62;
  localparam int unsigned ROOT_STEPS = 32;

  logic [LENGTH_W-1:0] length_fifo[$];
  logic [LENGTH_W-1:0] expected_len;
  int                  err_count    = 0;
  int                  pending_lens = 0;
  int unsigned         beats_out    = 0;

  assign mismatches = err_count;
  assign in_flight  = pending_lens;

  function automatic logic [63:0] square_of(input logic [FIELD_W-1:0] c);
    logic [63:0] mag;
    if (c[FIELD_W-1]) begin
      mag = {{(64-FIELD_W){1'b0}}, ~c} + 64'd1;
    end else begin
      mag = {{(64-FIELD_W){1'b0}}, c};
    end
    return mag * mag;
  endfunction

  // floor sqrt of the summed squares, one bit pair per step
  function automatic logic [LENGTH_W-1:0] euclid_length(input logic [FIELD_W-1:0] x,
                                                         input logic [FIELD_W-1:0] y,
                                                         input logic [FIELD_W-1:0] z);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] pair;
    logic [63:0] trial;
    rem  = square_of(x) + square_of(y) + square_of(z);
    root = 64'd0;
    pair = 64'd1 << TOP_PAIR;
    for (int i = 0; i < ROOT_STEPS; i++) begin
      trial = root + pair;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root >> 1) + pair;
      end else begin
        root = root >> 1;
      end
      pair = pair >> 2;
    end
    return root[LENGTH_W-1:0];
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t, length beat %0d: %s", $time, beats_out, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (length_fifo.size() == 0) begin
          flag_mismatch($sformatf("length %h with no vector pending", res.length));
        end else begin
          expected_len = length_fifo.pop_front();
          if (res.length !== expected_len) begin
            flag_mismatch($sformatf("length %h, expected %h", res.length, expected_len));
          end
        end
        beats_out++;
      end
      if (vec.valid && vec.ready) begin
        length_fifo.push_back(euclid_length(vec.x_component, vec.y_component,
                                            vec.z_component));
      end
      pending_lens <= length_fifo.size();
    end
  end
endmodule

>>> tb/vector_norm_q16_tb.sv
// testbench top: drives vectors and output stalls, gives the verdict
module vector_norm_q16_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vn_pkg::*;

  localparam int unsigned PHASES         = 4;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   src_idle_on  = 1'b0;
  bit   sink_idle_on = 1'b0;
  int   mismatches;
  int   in_flight;
  int unsigned quiet_cycles;

  vn_vec_if vec_if();
  vn_len_if len_if();

  vector_norm_q16 i_dut (
    .clk (clk),
    .rst (rst),
    .vec (vec_if),
    .res (len_if)
  );

  vn_norm_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .vec        (vec_if),
    .res        (len_if),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  always #5 clk = ~clk;

  function automatic logic [FIELD_W-1:0] pick_component();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
      3, 4: begin
        v = $urandom >> $urandom_range(8, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_vector(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                             input logic [FIELD_W-1:0] z);
    vec_if.valid       <= 1'b1;
    vec_if.x_component <= x;
    vec_if.y_component <= y;
    vec_if.z_component <= z;
    @(posedge clk);
    while (!vec_if.ready) @(posedge clk);
  endtask

  task automatic src_gap();
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      vec_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    vec_if.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  // output side stalls
  initial begin
    len_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        len_if.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        len_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        len_if.ready <= 1'b1;
      end else begin
        len_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((vec_if.valid && vec_if.ready) || (len_if.valid && len_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    vec_if.valid       <= 1'b0;
    vec_if.x_component <= '0;
    vec_if.y_component <= '0;
    vec_if.z_component <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_vector(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vector(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_vector(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    send_vector(32'h0003_0000, 32'hfffc_0000, 32'h0000_0000);
    src_gap();
    send_vector(32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
    send_vector(32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000);
    send_vector(32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff);
    send_vector(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vector(32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
    send_vector(32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
    src_gap();
    // largest lengths, well above 2^31, then mixed bit patterns
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001);
    send_vector(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    send_vector(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_vector(32'h0000_ffff, 32'hffff_0000, 32'h00ff_ff00);
    send_vector(32'h8000_0001, 32'h0000_0002, 32'hffff_fffe);

    for (int p = 0; p < PHASES; p++) begin
      src_idle_on  = (p == 0) || (p == 1);
      sink_idle_on = (p == 0) || (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_vector(pick_component(), pick_component(), pick_component());
        src_gap();
      end
      if (p == 1) hold_until_drained();
    end

    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/vn_pkg.sv
rtl/vn_vec_if.sv
rtl/vn_len_if.sv
rtl/vn_lane.sv
rtl/vn_merge.sv
rtl/vn_root.sv
rtl/vector_norm_q16.sv
tb/vn_norm_checker.sv
tb/vector_norm_q16_tb.sv
